// File: rtl/wkb_geometry_stream_parser_top_assert.svh
// assertion macros for the wkb parser checker
`ifndef WKB_GEOMETRY_STREAM_PARSER_TOP_ASSERT_SVH
`define WKB_GEOMETRY_STREAM_PARSER_TOP_ASSERT_SVH
// implication checked at every rising clock edge outside reset
`define WKB_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("wkb check failed");
// next-cycle implication checked at every rising clock edge outside reset
`define WKB_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("wkb check failed");
`endif

// File: rtl/wkb_pkg.sv
// ----------------------------------------------------------------------------
// wkb_pkg
// shared types and constants of the wkb geometry stream parser
// ----------------------------------------------------------------------------
`default_nettype none
package wkb_pkg;
   localparam int MaxDepth   = 8;
   localparam int LvlW       = $clog2(MaxDepth + 1);
   localparam int IdxW       = $clog2(MaxDepth);
   localparam int HeaderLen  = 39;
   localparam int MemberHdr  = 5;
   localparam int QDepth     = 4;
   localparam int QPtrW      = $clog2(QDepth);
   localparam int OQDepth    = 4;
   localparam int OQPtrW     = $clog2(OQDepth);

   // geometry codes of the type words
   localparam logic [1:0] GeoPoint = 2'd1;
   localparam logic [1:0] GeoLine  = 2'd2;
   localparam logic [1:0] GeoPoly  = 2'd3;
   localparam logic [2:0] GeoColl  = 3'd7;

   typedef enum logic [1:0] {
      EV_COORD = 2'd0, EV_EMPTY = 2'd1, EV_DONE = 2'd2, EV_FAIL = 2'd3
   } event_type;

   typedef enum logic [1:0] {
      ERR_NONE = 2'd0, ERR_TYPE = 2'd1, ERR_TRUNC = 2'd2, ERR_DEEP = 2'd3
   } err_type;

   typedef enum logic [10:0] {
      PH_START  = 11'b00000000001,
      PH_HEADER = 11'b00000000010,
      PH_TYPE   = 11'b00000000100,
      PH_MCOUNT = 11'b00000001000,
      PH_RCOUNT = 11'b00000010000,
      PH_PCOUNT = 11'b00000100000,
      PH_X      = 11'b00001000000,
      PH_Y      = 11'b00010000000,
      PH_ZM     = 11'b00100000000,
      PH_MHDR   = 11'b01000000000,
      PH_CORDER = 11'b10000000000
   } phase_type;

   // one classified byte handed from front to back
   typedef struct packed {
      logic [7:0] data;
      logic       last;
      logic       fmt;
   } byte_type;

   typedef struct packed {
      logic [1:0]  kind;
      logic [63:0] x;
      logic [63:0] y;
      logic [1:0]  simple;
      logic        gstart;
      logic        rstart;
      logic [3:0]  level;
      logic [1:0]  err;
      logic        rend;
   } result_type;
endpackage
`default_nettype wire

// File: rtl/wkb_front.sv
// ----------------------------------------------------------------------------
// wkb_front
// input item queue: takes bytes with the format bit and hands them on
// ----------------------------------------------------------------------------
`default_nettype none
module wkb_front (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              push,
   output logic                   full,
   input  wire logic [7:0]        req_data_byte,
   input  wire logic              req_last_byte,
   input  wire logic              fmt,
   output logic                   item_valid,
   input  wire logic              item_take,
   output wkb_pkg::byte_type      item
);
   wkb_pkg::byte_type q_ff [wkb_pkg::QDepth];
   logic [wkb_pkg::QPtrW-1:0] wr_ff, wr_in, rd_ff, rd_in;
   logic [wkb_pkg::QPtrW:0]   cnt_ff, cnt_in;
   logic do_push, do_pop;

   assign full       = (cnt_ff == (wkb_pkg::QPtrW+1)'(wkb_pkg::QDepth));
   assign item_valid = (cnt_ff != '0);
   assign item       = q_ff[rd_ff];
   assign do_push    = push && !full;
   assign do_pop     = item_take && item_valid;

   always_comb begin
      wr_in  = do_push ? wr_ff + 1'b1 : wr_ff;
      rd_in  = do_pop ? rd_ff + 1'b1 : rd_ff;
      cnt_in = cnt_ff + (wkb_pkg::QPtrW+1)'(do_push) - (wkb_pkg::QPtrW+1)'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
      if (do_push) begin
         q_ff[wr_ff] <= '{data: req_data_byte, last: req_last_byte, fmt: fmt};
      end
   end
endmodule
`default_nettype wire

// File: rtl/wkb_back.sv
// ----------------------------------------------------------------------------
// wkb_back
// parse engine: one byte per cycle while two slots are free, up to two results into the output queue
// ----------------------------------------------------------------------------
`default_nettype none
module wkb_back (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              item_valid,
   output logic                   item_take,
   input  wire wkb_pkg::byte_type item,
   output logic                   rsp_empty,
   input  wire logic              rsp_pop,
   output wkb_pkg::result_type    rsp
);
   wkb_pkg::phase_type ph_ff, ph_in;
   logic [5:0]  bc_ff, bc_in;
   logic [63:0] sh_ff, sh_in, xh_ff, xh_in;
   logic        sw_ff, sw_in, drop_ff, drop_in;
   logic [4:0]  ex_ff, ex_in;
   logic [wkb_pkg::LvlW-1:0] lp_ff, lp_in;
   logic [1:0]  cs_ff, cs_in;
   logic        gp_ff, gp_in, rp_ff, rp_in, bp_ff, bp_in;
   logic [30:0] rl_ff, rl_in, pl_ff, pl_in;
   logic [2:0]  lk_ff [wkb_pkg::MaxDepth];
   logic [30:0] lr_ff [wkb_pkg::MaxDepth];
   logic [4:0]  le_ff [wkb_pkg::MaxDepth];
   logic        lw_en, lr_en;
   logic [wkb_pkg::IdxW-1:0] lw_idx;
   logic [2:0]  lw_kind;
   logic [30:0] lw_rem;
   logic [4:0]  lw_ex;

   wkb_pkg::result_type oq_ff [wkb_pkg::OQDepth];
   logic [wkb_pkg::OQPtrW-1:0] owr_ff, ord_ff;
   logic [wkb_pkg::OQPtrW:0]   ocnt_ff;
   wkb_pkg::result_type e0, e1;
   logic [1:0] ne;
   logic go, done;

   assign rsp_empty = (ocnt_ff == '0);
   assign rsp       = oq_ff[ord_ff];
   // need room for two results
   assign item_take = (ocnt_ff <= (wkb_pkg::OQPtrW+1)'(wkb_pkg::OQDepth - 2));
   assign go        = item_valid && item_take;

   function automatic logic is_nan(input logic [63:0] b);
      is_nan = (b[62:52] == 11'h7ff) && (b[51:0] != '0);
   endfunction

   always_comb begin : engine
      logic [31:0] v;
      logic [5:0]  nbc, width;
      logic [3:0]  th;
      logic [9:0]  base;
      logic        fin, walk, sg, terr;
      logic [1:0]  ferr;
      logic [2:0]  sbase;
      logic [4:0]  sext;
      logic        sbare;
      logic [wkb_pkg::LvlW-1:0] lp;
      logic [wkb_pkg::IdxW-1:0] ti;
      logic [30:0] cnt, cur_rem, pl;
      logic [63:0] shn;
      ph_in = ph_ff; bc_in = bc_ff; sh_in = sh_ff; xh_in = xh_ff; sw_in = sw_ff;
      drop_in = drop_ff; ex_in = ex_ff; lp_in = lp_ff; cs_in = cs_ff;
      gp_in = gp_ff; rp_in = rp_ff; bp_in = bp_ff; rl_in = rl_ff; pl_in = pl_ff;
      lw_en = 1'b0; lr_en = 1'b0; lw_idx = '0; lw_kind = '0; lw_rem = '0; lw_ex = '0;
      e0 = '0; e1 = '0; ne = 2'd0;
      fin = 1'b0; ferr = wkb_pkg::ERR_NONE; walk = 1'b0; sg = 1'b0;
      sbase = '0; sext = '0; sbare = 1'b0; done = 1'b0;
      v = sh_ff[31:0]; nbc = bc_ff + 6'd1; width = 6'd4;
      th = '0; base = '0; terr = 1'b0; lp = lp_ff; ti = '0; cnt = '0;
      cur_rem = '0; pl = '0; shn = '0;
      if (go) begin
         if (drop_ff) begin
            if (item.last) begin
               drop_in = 1'b0;
               done = 1'b1;
            end
         end else begin
            unique case (ph_ff)
               wkb_pkg::PH_START: begin
                  if (item.fmt) begin
                     bc_in = 6'd1; ph_in = wkb_pkg::PH_HEADER;
                  end else begin
                     sw_in = (item.data == 8'd0);
                     ph_in = wkb_pkg::PH_TYPE; bc_in = '0; sh_in = '0;
                  end
               end
               wkb_pkg::PH_HEADER: begin
                  if (bc_ff == 6'd1) sw_in = (item.data == 8'd0);
                  bc_in = nbc;
                  if (nbc >= 6'(wkb_pkg::HeaderLen)) begin
                     ph_in = wkb_pkg::PH_TYPE; bc_in = '0; sh_in = '0;
                  end
               end
               wkb_pkg::PH_ZM: begin
                  bc_in = nbc;
                  if (nbc >= {1'b0, ex_ff}) walk = 1'b1;
               end
               wkb_pkg::PH_MHDR: begin
                  bc_in = nbc;
                  if (nbc >= 6'(wkb_pkg::MemberHdr)) begin
                     if (lp_ff == '0) begin
                        fin = 1'b1;
                     end else begin
                        ti = (wkb_pkg::IdxW)'(lp_ff - 1'b1);
                        sg = 1'b1; sbase = lk_ff[ti] - 3'd3;
                        sext = le_ff[ti]; sbare = 1'b0;
                     end
                  end
               end
               wkb_pkg::PH_CORDER: begin
                  ph_in = wkb_pkg::PH_TYPE; bc_in = '0; sh_in = '0;
               end
               default: begin
                  // field assembly
                  if (ph_ff == wkb_pkg::PH_X || ph_ff == wkb_pkg::PH_Y) width = 6'd8;
                  if (sw_ff) shn = {sh_ff[55:0], item.data};
                  else shn = sh_ff | (64'(item.data) << {bc_ff[2:0], 3'b000});
                  sh_in = shn; bc_in = nbc;
                  v = shn[31:0];
                  cnt = v[31] ? '0 : v[30:0];
                  if (nbc >= width) begin
                     priority case (1'b1)
                        ph_ff == wkb_pkg::PH_TYPE: begin
                           // thousands digit by range compare
                           if (v < 32'd1000) begin th = 4'd0; base = v[9:0]; end
                           else if (v < 32'd2000) begin th = 4'd1; base = 10'(v - 32'd1000); end
                           else if (v < 32'd3000) begin th = 4'd2; base = 10'(v - 32'd2000); end
                           else if (v < 32'd4000) begin th = 4'd3; base = 10'(v - 32'd3000); end
                           else terr = 1'b1;
                           if (terr || base < 10'd1 || base > 10'd7) begin
                              fin = 1'b1; ferr = wkb_pkg::ERR_TYPE;
                           end else begin
                              sg = 1'b1; sbase = base[2:0]; sbare = 1'b1;
                              sext = (th == 4'd0) ? 5'd0 : (th == 4'd3 ? 5'd16 : 5'd8);
                           end
                        end
                        ph_ff == wkb_pkg::PH_MCOUNT: begin
                           lw_en = 1'b1; lw_idx = (wkb_pkg::IdxW)'(lp_ff - 1'b1);
                           lr_en = 1'b1; lw_rem = cnt;
                           walk = 1'b1;
                        end
                        ph_ff == wkb_pkg::PH_RCOUNT: begin
                           if (cnt == '0) begin
                              rl_in = '0; walk = 1'b1;
                           end else begin
                              rl_in = cnt - 31'd1;
                              ph_in = wkb_pkg::PH_PCOUNT; bc_in = '0; sh_in = '0;
                           end
                        end
                        ph_ff == wkb_pkg::PH_PCOUNT: begin
                           pl_in = cnt;
                           if (cnt == '0) begin
                              e0 = '0; e0.kind = wkb_pkg::EV_EMPTY; e0.simple = cs_ff;
                              e0.gstart = gp_ff; e0.level = 4'(lp_ff); ne = 2'd1;
                              gp_in = 1'b0;
                              if (cs_ff == wkb_pkg::GeoPoly && rl_ff != '0) begin
                                 rl_in = rl_ff - 31'd1;
                                 ph_in = wkb_pkg::PH_PCOUNT; bc_in = '0; sh_in = '0;
                              end else walk = 1'b1;
                           end else begin
                              rp_in = 1'b1;
                              ph_in = wkb_pkg::PH_X; bc_in = '0; sh_in = '0;
                           end
                        end
                        ph_ff == wkb_pkg::PH_X: begin
                           xh_in = shn; ph_in = wkb_pkg::PH_Y; bc_in = '0; sh_in = '0;
                        end
                        default: begin
                           if (!(cs_ff == wkb_pkg::GeoPoint && bp_ff &&
                                 (is_nan(xh_ff) || is_nan(shn))))
                           begin
                              e0 = '0; e0.kind = wkb_pkg::EV_COORD; e0.x = xh_ff; e0.y = shn;
                              e0.simple = cs_ff; e0.gstart = gp_ff;
                              e0.rstart = (cs_ff == wkb_pkg::GeoPoint) ? 1'b0 : rp_ff;
                              e0.level = 4'(lp_ff); ne = 2'd1;
                           end
                           gp_in = 1'b0; rp_in = 1'b0;
                           if (ex_ff != '0) begin
                              ph_in = wkb_pkg::PH_ZM; bc_in = '0;
                           end else walk = 1'b1;
                        end
                     endcase
                  end
               end
            endcase
            // after-point handling for coordinate and zm ends
            if (walk && (ph_ff == wkb_pkg::PH_Y || ph_ff == wkb_pkg::PH_ZM)) begin
               if (cs_ff != wkb_pkg::GeoPoint) begin
                  pl = (pl_ff != '0) ? pl_ff - 31'd1 : pl_ff;
                  pl_in = pl;
                  if (pl != '0) begin
                     walk = 1'b0;
                     ph_in = wkb_pkg::PH_X; bc_in = '0; sh_in = '0;
                  end else if (cs_ff == wkb_pkg::GeoPoly && rl_ff != '0) begin
                     walk = 1'b0; rl_in = rl_ff - 31'd1;
                     ph_in = wkb_pkg::PH_PCOUNT; bc_in = '0; sh_in = '0;
                  end
               end
            end
            // next member: pop exhausted levels, one compare per level
            if (walk) begin
               lp = lp_ff;
               for (int i = wkb_pkg::MaxDepth; i >= 1; i--) begin
                  if (lp == (wkb_pkg::LvlW)'(i)) begin
                     cur_rem = (lr_en && lw_idx == (wkb_pkg::IdxW)'(i - 1)) ? lw_rem :
                               lr_ff[i-1];
                     if (cur_rem == '0) lp = lp - 1'b1;
                  end
               end
               lp_in = lp;
               if (lp == '0) begin
                  fin = 1'b1;
               end else begin
                  ti = (wkb_pkg::IdxW)'(lp - 1'b1);
                  cur_rem = (lr_en && lw_idx == ti) ? lw_rem : lr_ff[ti];
                  lw_en = 1'b1; lr_en = 1'b1; lw_idx = ti; lw_rem = cur_rem - 31'd1;
                  ph_in = (lk_ff[ti] == wkb_pkg::GeoColl) ? wkb_pkg::PH_CORDER :
                                                            wkb_pkg::PH_MHDR;
                  bc_in = '0; sh_in = '0;
               end
            end
            if (sg) begin
               if (sbase != 3'd0 && sbase <= {1'b0, wkb_pkg::GeoPoly}) begin
                  cs_in = sbase[1:0]; ex_in = sext; bp_in = sbare;
                  gp_in = 1'b1; rp_in = 1'b0; bc_in = '0; sh_in = '0;
                  ph_in = (sbase[1:0] == wkb_pkg::GeoPoint) ? wkb_pkg::PH_X :
                          (sbase[1:0] == wkb_pkg::GeoLine ? wkb_pkg::PH_PCOUNT :
                                                            wkb_pkg::PH_RCOUNT);
               end else if (lp_ff >= (wkb_pkg::LvlW)'(wkb_pkg::MaxDepth)) begin
                  fin = 1'b1; ferr = wkb_pkg::ERR_DEEP;
               end else begin
                  lw_en = 1'b1; lr_en = 1'b1; lw_idx = (wkb_pkg::IdxW)'(lp_ff);
                  lw_kind = sbase; lw_ex = sext; lw_rem = '0;
                  lp_in = lp_ff + 1'b1;
                  ph_in = wkb_pkg::PH_MCOUNT; bc_in = '0; sh_in = '0;
               end
            end
            if (!fin && item.last) begin
               fin = 1'b1; ferr = wkb_pkg::ERR_TRUNC;
            end
            if (fin) begin
               e1 = '0;
               e1.kind = (ferr == wkb_pkg::ERR_NONE) ? wkb_pkg::EV_DONE : wkb_pkg::EV_FAIL;
               e1.err = ferr; e1.rend = 1'b1;
               if (ne == 2'd0) e0 = e1;
               ne = ne + 2'd1;
               drop_in = !item.last;
               done = 1'b1;
            end
         end
         if (done) begin
            ph_in = wkb_pkg::PH_START; bc_in = '0; sh_in = '0; lp_in = '0;
            ex_in = '0; cs_in = '0; gp_in = 1'b0; rp_in = 1'b0; bp_in = 1'b0;
            rl_in = '0; pl_in = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ph_ff <= wkb_pkg::PH_START; bc_ff <= '0; sh_ff <= '0; xh_ff <= '0;
         sw_ff <= 1'b0; drop_ff <= 1'b0; ex_ff <= '0; lp_ff <= '0; cs_ff <= '0;
         gp_ff <= 1'b0; rp_ff <= 1'b0; bp_ff <= 1'b0; rl_ff <= '0; pl_ff <= '0;
         owr_ff <= '0; ord_ff <= '0; ocnt_ff <= '0;
      end else begin
         ph_ff <= ph_in; bc_ff <= bc_in; sh_ff <= sh_in; xh_ff <= xh_in;
         sw_ff <= sw_in; drop_ff <= drop_in; ex_ff <= ex_in; lp_ff <= lp_in;
         cs_ff <= cs_in; gp_ff <= gp_in; rp_ff <= rp_in; bp_ff <= bp_in;
         rl_ff <= rl_in; pl_ff <= pl_in;
         owr_ff <= owr_ff + (wkb_pkg::OQPtrW)'(ne);
         ord_ff <= ord_ff + (wkb_pkg::OQPtrW)'(rsp_pop && !rsp_empty);
         ocnt_ff <= ocnt_ff + (wkb_pkg::OQPtrW+1)'(ne)
                    - (wkb_pkg::OQPtrW+1)'(rsp_pop && !rsp_empty);
      end
      if (ne != 2'd0) oq_ff[owr_ff] <= e0;
      if (ne == 2'd2) oq_ff[owr_ff + 1'b1] <= e1;
      if (lw_en) begin
         lr_ff[lw_idx] <= lw_rem;
         if (lw_kind != '0) begin
            lk_ff[lw_idx] <= lw_kind;
            le_ff[lw_idx] <= lw_ex;
         end
      end
   end
endmodule
`default_nettype wire

// File: rtl/wkb_geometry_stream_parser_top.sv
// ----------------------------------------------------------------------------
// wkb_geometry_stream_parser_top
// wkb record parser: bytes in, coordinate and status items out
// ----------------------------------------------------------------------------
// channel   direction  handshake            payload
// req       in         push / full          data_byte, last_byte
// rsp       out        pop / empty          event_kind .. record_end
// csr       in         valid / ready        record_format
//
// one byte per cycle sustained while result slots are free; a byte yields at most two result items
// the back end stalls while fewer than two result slots are free
// a four-entry byte queue parts the input side from the parse engine
// reset is synchronous and clears all control state; no clearing pass
// ----------------------------------------------------------------------------
`default_nettype none
module wkb_geometry_stream_parser_top (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        push,
   output logic             full,
   input  wire logic [7:0]  req_data_byte,
   input  wire logic        req_last_byte,
   output logic             empty,
   input  wire logic        pop,
   output logic [1:0]       rsp_event_kind,
   output logic [63:0]      rsp_x_bits,
   output logic [63:0]      rsp_y_bits,
   output logic [1:0]       rsp_simple_type,
   output logic             rsp_geometry_start,
   output logic             rsp_ring_start,
   output logic [3:0]       rsp_nest_level,
   output logic [1:0]       rsp_error_code,
   output logic             rsp_record_end,
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic        csr_record_format
);
   logic fmt_ff;
   logic item_valid, item_take;
   wkb_pkg::byte_type item;
   wkb_pkg::result_type rsp;

   assign csr_ready = 1'b1;
   always_ff @(posedge clock) begin
      if (reset) fmt_ff <= 1'b0;
      else if (csr_valid) fmt_ff <= csr_record_format;
   end

   wkb_front u_front (
      .clock, .reset, .push, .full, .req_data_byte, .req_last_byte,
      .fmt(fmt_ff), .item_valid, .item_take, .item
   );

   wkb_back u_back (
      .clock, .reset, .item_valid, .item_take, .item,
      .rsp_empty(empty), .rsp_pop(pop), .rsp
   );

   assign rsp_event_kind     = rsp.kind;
   assign rsp_x_bits         = rsp.x;
   assign rsp_y_bits         = rsp.y;
   assign rsp_simple_type    = rsp.simple;
   assign rsp_geometry_start = rsp.gstart;
   assign rsp_ring_start     = rsp.rstart;
   assign rsp_nest_level     = rsp.level;
   assign rsp_error_code     = rsp.err;
   assign rsp_record_end     = rsp.rend;
endmodule
`default_nettype wire

// File: rtl/wkb_checker.sv
// ----------------------------------------------------------------------------
// wkb_checker
// port-level checks of the wkb parser
// ----------------------------------------------------------------------------
`default_nettype none
`include "wkb_geometry_stream_parser_top_assert.svh"
module wkb_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        empty,
   input wire logic        pop,
   input wire logic [1:0]  rsp_event_kind,
   input wire logic [1:0]  rsp_error_code,
   input wire logic        rsp_record_end,
   input wire logic [63:0] rsp_x_bits
);
   logic is_fail, is_done;

   assign is_fail = !empty && (rsp_event_kind == wkb_pkg::EV_FAIL);
   assign is_done = !empty && (rsp_event_kind == wkb_pkg::EV_DONE);

   `WKB_ASSERT_IMPL(a_end_kind, clock, reset, !empty && rsp_record_end, rsp_event_kind[1])
   `WKB_ASSERT_IMPL(a_fail_err, clock, reset, is_fail, rsp_error_code != wkb_pkg::ERR_NONE)
   `WKB_ASSERT_IMPL(a_done_zero, clock, reset, is_done, rsp_x_bits == 64'd0)
   `WKB_ASSERT_NEXT(a_hold, clock, reset, !empty && !pop, !empty)
endmodule
bind wkb_geometry_stream_parser_top wkb_checker u_wkb_checker (
   .clock, .reset, .empty, .pop, .rsp_event_kind, .rsp_error_code,
   .rsp_record_end, .rsp_x_bits
);
`default_nettype wire
